// ===== rtl/kear_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_pkg
// Shared types and constants for the key edge and auto-repeat block.
// ----------------------------------------------------------------------------
package kear_pkg;

  localparam int unsigned FieldW = 10;  // width of every key mask field
  localparam int unsigned CntW   = 8;   // per-key countdown width
  localparam int unsigned CfgIdxW = 8;  // configuration index width

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_FIRST_DELAY  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_REPEAT_DELAY = 8'd1;

  // reset values of the configuration registers
  localparam logic [CntW-1:0] FIRST_DELAY_RST  = 8'd20;
  localparam logic [CntW-1:0] REPEAT_DELAY_RST = 8'd5;

  typedef struct packed {
    logic [CntW-1:0] first_dly;
    logic [CntW-1:0] rpt_dly;
  } kear_delay_t;

  typedef struct packed {
    logic advance;  // a tick is transferred this cycle
    logic held;     // key is pressed in this tick
  } kear_key_ctrl_t;

endpackage

// ===== rtl/kear_key_cnt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_key_cnt
// Countdown for one key: reloads while released, counts down while held and
// flags a repeat when it reaches zero.
// ----------------------------------------------------------------------------
module kear_key_cnt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kear_pkg::kear_key_ctrl_t ctrl_i,
  input  kear_pkg::kear_delay_t  delay_i,
  output logic                   rep_o
);
  import kear_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (!ctrl_i.held) begin
      cnt_d = delay_i.first_dly;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - {{(CntW-1){1'b0}}, 1'b1};
    end else begin
      cnt_d = delay_i.rpt_dly;
    end
  end

  // valid only in a cycle where advance is high
  assign rep_o = ctrl_i.held && (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.advance) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/kear_edge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_edge
// Keeps the previous tick's key vector and finds press and release edges.
// ----------------------------------------------------------------------------
module kear_edge #(
  parameter int unsigned KeyCount = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [KeyCount-1:0] keys_i,
  output logic [KeyCount-1:0] pressed_o,
  output logic [KeyCount-1:0] released_o
);

  logic [KeyCount-1:0] prev_q;
  logic [KeyCount-1:0] changed;

  assign changed    = keys_i ^ prev_q;
  assign pressed_o  = changed & keys_i;
  assign released_o = changed & prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (advance_i) begin
      prev_q <= keys_i;
    end
  end

endmodule

// ===== rtl/key_edge_and_autorepeat_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_edge_and_autorepeat_top
// Keypad edge detector with per-key auto-repeat countdowns.
// ----------------------------------------------------------------------------
// One frame tick is taken per clock cycle while the input is not stalled.
// Its result appears in the output register on the cycle after the input
// transfer, set by the single pass through the edge masks and the per-key
// countdown update into that register. The input is stalled
// only while a result waits in the output register and the
// output side stalls. Configuration writes are always taken (ready is high);
// writes to an index other than the two delay registers are dropped. Only the
// low KEY_COUNT bits of keys_held_i are keys; other field bits read as zero.
// ----------------------------------------------------------------------------
module key_edge_and_autorepeat_top #(
  parameter int unsigned KEY_COUNT = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kear_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kear_pkg::CntW-1:0]     cfg_data_i,
  // tick input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kear_pkg::FieldW-1:0]   keys_held_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kear_pkg::FieldW-1:0]   held_now_o,
  output logic [kear_pkg::FieldW-1:0]   newly_pressed_o,
  output logic [kear_pkg::FieldW-1:0]   newly_released_o,
  output logic [kear_pkg::FieldW-1:0]   press_or_repeat_o
);
  import kear_pkg::*;

  kear_delay_t delay_q;

  logic in_xfer;
  logic out_valid_q;

  logic [KEY_COUNT-1:0] keys;
  logic [KEY_COUNT-1:0] pressed;
  logic [KEY_COUNT-1:0] released;
  logic [KEY_COUNT-1:0] rep;

  logic [FieldW-1:0] held_d, pressed_d, released_d, por_d;
  logic [FieldW-1:0] held_q, pressed_q, released_q, por_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q.first_dly <= FIRST_DELAY_RST;
      delay_q.rpt_dly   <= REPEAT_DELAY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_FIRST_DELAY:  delay_q.first_dly <= cfg_data_i;
        REG_REPEAT_DELAY: delay_q.rpt_dly   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: take a tick unless a result is held up downstream
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // key vector: keys beyond the field width are never held
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_keys
    if (k < FieldW) begin : g_in
      assign keys[k] = keys_held_i[k];
    end else begin : g_none
      assign keys[k] = 1'b0;
    end
  end

  kear_edge #(
    .KeyCount(KEY_COUNT)
  ) u_edge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (in_xfer),
    .keys_i     (keys),
    .pressed_o  (pressed),
    .released_o (released)
  );

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_cnt
    kear_key_ctrl_t ctrl;
    assign ctrl.advance = in_xfer;
    assign ctrl.held    = keys[k];

    kear_key_cnt u_cnt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .delay_i (delay_q),
      .rep_o   (rep[k])
    );
  end

  // map key vectors onto the fixed-width result fields
  for (genvar j = 0; j < FieldW; j++) begin : g_field
    if (j < KEY_COUNT) begin : g_key
      assign held_d[j]     = keys[j];
      assign pressed_d[j]  = pressed[j];
      assign released_d[j] = released[j];
      assign por_d[j]      = pressed[j] | rep[j];
    end else begin : g_pad
      assign held_d[j]     = 1'b0;
      assign pressed_d[j]  = 1'b0;
      assign released_d[j] = 1'b0;
      assign por_d[j]      = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      held_q     <= held_d;
      pressed_q  <= pressed_d;
      released_q <= released_d;
      por_q      <= por_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign held_now_o        = held_q;
  assign newly_pressed_o   = pressed_q;
  assign newly_released_o  = released_q;
  assign press_or_repeat_o = por_q;

  // a transferred tick always shows up in the result register next cycle
  a_xfer_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("tick transfer did not produce a result");

  // never overwrite a result that is held up downstream
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !in_xfer)
    else $error("result overwritten while stalled");

  // a key cannot be pressed and released in the same tick
  a_edges_disjoint : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((newly_pressed_o & newly_released_o) == '0))
    else $error("press and release edge on the same key");

  // press edges are held and always in press_or_repeat; releases are not held
  a_press_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (((newly_pressed_o & ~held_now_o) == '0) &&
                     ((newly_pressed_o & ~press_or_repeat_o) == '0) &&
                     ((newly_released_o & held_now_o) == '0)))
    else $error("edge masks inconsistent with held keys");

  // repeats only come from held keys
  a_repeat_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((press_or_repeat_o & ~held_now_o) == '0))
    else $error("repeat reported for a released key");

endmodule
